[hw/rtl/mcpg_pkg.sv]
// Package: shared constants, types and codes for the midpoint circle point generator.
`timescale 1ns / 1ps

package mcpg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int DEC_BITS    = RADIUS_BITS + 4;
  localparam int CENTER_BITS = 12;
  localparam int POINT_BITS  = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DIAG_ADD = DEC_BITS'(10);
  localparam logic [DEC_BITS-1:0] AXIS_ADD = DEC_BITS'(6);

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [CENTER_BITS-1:0] cx;
    logic signed [CENTER_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0]        x;
    logic [RADIUS_BITS-1:0]        y;
    logic                          done;
  } work_t;

endpackage

[hw/rtl/mcpg_front.sv]
// Front end: accepts items, runs the midpoint decision walk, posts work records.
`timescale 1ns / 1ps

module mcpg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [mcpg_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [mcpg_pkg::CENTER_BITS-1:0] center_y,
  input  logic [mcpg_pkg::RADIUS_BITS-1:0]     radius,
  input  logic                                 q_full,
  output logic                                 push,
  output mcpg_pkg::work_t                      rec
);

  logic [mcpg_pkg::RADIUS_BITS-1:0]     octant_x, octant_x_next;
  logic [mcpg_pkg::RADIUS_BITS-1:0]     octant_y, octant_y_next;
  logic [mcpg_pkg::DEC_BITS-1:0]        decision, decision_next;
  logic signed [mcpg_pkg::CENTER_BITS-1:0] held_cx, held_cx_next;
  logic signed [mcpg_pkg::CENTER_BITS-1:0] held_cy, held_cy_next;
  logic                                 busy, busy_next;

  logic                                 accept;
  logic                                 done;
  logic [mcpg_pkg::RADIUS_BITS-1:0]     xs, ys;
  logic [mcpg_pkg::DEC_BITS-1:0]        diff;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    octant_x_next = octant_x;
    octant_y_next = octant_y;
    decision_next = decision;
    held_cx_next  = held_cx;
    held_cy_next  = held_cy;
    busy_next     = busy;
    push          = 1'b0;
    done          = 1'b0;
    xs            = mcpg_pkg::RADIUS_BITS'(octant_x + 1'b1);
    ys            = mcpg_pkg::RADIUS_BITS'(octant_y - 1'b1);
    diff          = mcpg_pkg::DEC_BITS'(xs) - mcpg_pkg::DEC_BITS'(ys);
    if (accept) begin
      if (mcpg_pkg::kind_t'(kind) == mcpg_pkg::KIND_START) begin
        held_cx_next  = center_x;
        held_cy_next  = center_y;
        octant_x_next = '0;
        octant_y_next = radius;
        decision_next = mcpg_pkg::DEC_INIT - (mcpg_pkg::DEC_BITS'(radius) << 1);
        done          = (radius == '0);
        busy_next     = !done;
        push          = 1'b1;
      end else if (busy) begin
        octant_x_next = xs;
        if (!decision[mcpg_pkg::DEC_BITS-1] && (decision != '0)) begin
          octant_y_next = ys;
          decision_next = decision + (diff << 2) + mcpg_pkg::DIAG_ADD;
        end else begin
          decision_next = decision + (mcpg_pkg::DEC_BITS'(xs) << 2) + mcpg_pkg::AXIS_ADD;
        end
        done      = !(xs < octant_y_next);
        busy_next = !done;
        push      = 1'b1;
      end
    end
    rec.cx   = held_cx_next;
    rec.cy   = held_cy_next;
    rec.x    = octant_x_next;
    rec.y    = octant_y_next;
    rec.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octant_x <= '0;
      octant_y <= '0;
      decision <= '0;
      held_cx  <= '0;
      held_cy  <= '0;
      busy     <= 1'b0;
    end else begin
      octant_x <= octant_x_next;
      octant_y <= octant_y_next;
      decision <= decision_next;
      held_cx  <= held_cx_next;
      held_cy  <= held_cy_next;
      busy     <= busy_next;
    end
  end

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    push && rec.done |=> !busy)
    else $error("walk still busy after completing item");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !busy && (mcpg_pkg::kind_t'(kind) == mcpg_pkg::KIND_STEP) |=> !busy)
    else $error("step while idle started a walk");

endmodule

[hw/rtl/mcpg_queue.sv]
// Short queue of work records between front and back end.
`timescale 1ns / 1ps

module mcpg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mcpg_pkg::work_t wdata,
  input  logic            pop,
  output mcpg_pkg::work_t rdata,
  output logic            full,
  output logic            empty
);

  mcpg_pkg::work_t                    slots [mcpg_pkg::QUEUE_DEPTH];
  logic [mcpg_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [mcpg_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [mcpg_pkg::QCNT_BITS-1:0]     count;

  assign full  = (count == mcpg_pkg::QCNT_BITS'(mcpg_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mcpg_pkg::QPTR_BITS'(mcpg_pkg::QUEUE_DEPTH - 1)) ? '0
                  : mcpg_pkg::QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mcpg_pkg::QPTR_BITS'(mcpg_pkg::QUEUE_DEPTH - 1)) ? '0
                  : mcpg_pkg::QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= mcpg_pkg::QCNT_BITS'(count + 1'b1);
      end else if (pop && !push) begin
        count <= mcpg_pkg::QCNT_BITS'(count - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

[hw/rtl/mcpg_back.sv]
// Back end: expands each work record into its eight mirrored points.
`timescale 1ns / 1ps

module mcpg_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mcpg_pkg::work_t                         rdata,
  input  logic                                    empty,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mcpg_pkg::POINT_BITS-1:0]  point_x,
  output logic signed [mcpg_pkg::POINT_BITS-1:0]  point_y,
  output logic                                    last_of_run,
  output logic                                    circle_done
);

  mcpg_pkg::work_t cur;
  logic            active;
  logic [2:0]      k;
  logic            advance;
  logic            emit;

  logic signed [mcpg_pkg::POINT_BITS-1:0] ox, oy, dx, dy, px, py;

  assign advance = !out_valid || !out_stall;
  assign emit    = advance && active;
  assign pop     = !empty && (!active || (emit && (k == 3'd7)));

  always_comb begin
    ox = mcpg_pkg::POINT_BITS'(cur.x);
    oy = mcpg_pkg::POINT_BITS'(cur.y);
    if (k[0]) ox = -ox;
    if (k[1]) oy = -oy;
    if (k[2]) begin
      dx = oy;
      dy = ox;
    end else begin
      dx = ox;
      dy = oy;
    end
    px = mcpg_pkg::POINT_BITS'(cur.cx) + dx;
    py = mcpg_pkg::POINT_BITS'(cur.cy) + dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (emit) begin
        k <= 3'(k + 1'b1);
        if (k == 3'd7) begin
          active <= !empty;
        end
      end else if (!active && !empty) begin
        active <= 1'b1;
        k      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rdata;
    end
    if (emit) begin
      point_x     <= px;
      point_y     <= py;
      last_of_run <= (k == 3'd7);
      circle_done <= cur.done;
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a run of eight points");

  a_pop_on_boundary: assert property (@(posedge clk) disable iff (rst)
    pop && active |-> emit && (k == 3'd7))
    else $error("record replaced mid run");

endmodule

[hw/rtl/midpoint_circle_point_generator.sv]
// Top level: midpoint circle point generator with eight-way symmetry.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   kind, center_x, center_y, radius
//   output   out_valid / out_stall point_x, point_y, last_of_run, circle_done
//
// The front end updates the walk in the cycle an item is accepted, so items
// enter back to back until the two-entry record queue fills.
// The back end emits one point per cycle while out_stall is low, eight points
// per producing item. A step item while idle produces nothing.
// Reset (rst, synchronous) idles the walk and empties the queue.
// out_stall holds the output register; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module midpoint_circle_point_generator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic signed [mcpg_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [mcpg_pkg::CENTER_BITS-1:0] center_y,
  input  logic [mcpg_pkg::RADIUS_BITS-1:0]        radius,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mcpg_pkg::POINT_BITS-1:0]  point_x,
  output logic signed [mcpg_pkg::POINT_BITS-1:0]  point_y,
  output logic                                    last_of_run,
  output logic                                    circle_done
);

  mcpg_pkg::work_t wrec;
  mcpg_pkg::work_t rrec;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  mcpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_full   (q_full),
    .push     (push),
    .rec      (wrec)
  );

  mcpg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wrec),
    .pop   (pop),
    .rdata (rrec),
    .full  (q_full),
    .empty (q_empty)
  );

  mcpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rdata       (rrec),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_of_run (last_of_run),
    .circle_done (circle_done)
  );

endmodule
